// ===== rtl/rtpbt_pkg.sv =====
// Shared constants for the raster-to-page bit transposer.
// Frame geometry, counter widths and band store layout; no dependencies.
package rtpbt_pkg;

    localparam int DisplayWidth  = 128;
    localparam int DisplayHeight = 64;

    // bytes per row and rows per frame in each mode
    localparam int FullBpr  = DisplayWidth / 8;
    localparam int HalfBpr  = DisplayWidth / 16;
    localparam int FullRows = (DisplayHeight / 8) * 8;
    localparam int HalfRows = ((DisplayHeight / 2) / 4) * 4;

    // counter widths
    localparam int ColW = $clog2(FullBpr);
    localparam int RowW = $clog2(FullRows);

    // band store: one word per byte column, seven stored rows of one byte each
    localparam int StoreLanes = 7;
    localparam int StoreW     = StoreLanes * 8;

    // result beats per chunk
    localparam int FullBeats = 8;
    localparam int HalfBeats = 16;
    localparam int BeatW     = $clog2(HalfBeats);

    typedef logic [7:0] byte_t;

endpackage

// ===== rtl/raster_to_page_bit_transposer.sv =====
// Top level of the raster-to-page bit transposer.
// Uses rtpbt_pkg for geometry constants; holds the band store memory.
//
// Usage:
//   s_ channel: one raster pixel byte per word (msb leftmost pixel).
//   m_ channel: vertical page bytes, bit 0 the band's top row; m_tlast marks
//   the final word of a column chunk.
//   cfg channel: half_size_mode write; it restarts the frame at row 0,
//   column 0 and keeps the band store. Write only while the block is idle.
// Throughput: one input word per cycle while s_tready is high; bytes of non-final band rows go
//   straight into the band store. A byte of a band's last row loads a chunk
//   of 8 (full) or 16 (half) page words, emitted one per cycle while m_tready
//   is high, so the output port sets the rate.
// Path: an accepted last-row word passes the input stage, then the chunk register;
//   the first page word of the chunk goes valid once the chunk register loads.
// Reset: positions and mode go to zero, pipeline empties; the band store is
//   not cleared (every read entry is written first in the same mode).
// Stall: while m_tready is low the chunk holds; s_tready drops only when the
//   input stage holds a last-row byte that cannot yet enter the chunk register.
module raster_to_page_bit_transposer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] pixel_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] page_byte
    output logic       m_tlast,   // last_of_chunk
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data   // half_size_mode
);

    localparam int ColW   = rtpbt_pkg::ColW;
    localparam int RowW   = rtpbt_pkg::RowW;
    localparam int BeatW  = rtpbt_pkg::BeatW;
    localparam int StoreW = rtpbt_pkg::StoreW;

    // band store memory
    logic [StoreW-1:0] band_mem [rtpbt_pkg::FullBpr];

    logic            mode_reg;
    logic [ColW-1:0] col_reg;
    logic [RowW-1:0] row_reg;

    logic              s1_valid_reg;
    logic              s1_emit_reg;
    logic              s1_half_reg;
    rtpbt_pkg::byte_t  s1_px_reg;
    logic [StoreW-1:0] s1_rd_reg;

    logic             busy_reg;
    logic             out_half_reg;
    logic [BeatW-1:0] beat_reg;
    rtpbt_pkg::byte_t page_reg [8];
    rtpbt_pkg::byte_t page_next [8];

    logic            s_accept;
    logic            m_accept;
    logic            last_beat;
    logic            can_load;
    logic            s1_adv;
    logic            load;
    logic [2:0]      rib;
    logic            emit;
    logic [ColW-1:0] col_last;
    logic [RowW-1:0] row_last;
    rtpbt_pkg::byte_t chunk [8];

    assign cfg_ready = 1'b1;

    // band geometry of the current position
    always_comb begin
        if (mode_reg) begin
            rib      = {1'b0, row_reg[1:0]};
            emit     = (row_reg[1:0] == 2'd3);
            col_last = ColW'(rtpbt_pkg::HalfBpr - 1);
            row_last = RowW'(rtpbt_pkg::HalfRows - 1);
        end else begin
            rib      = row_reg[2:0];
            emit     = (row_reg[2:0] == 3'd7);
            col_last = ColW'(rtpbt_pkg::FullBpr - 1);
            row_last = RowW'(rtpbt_pkg::FullRows - 1);
        end
    end

    // handshake and pipeline advance
    assign m_tvalid  = busy_reg;
    assign m_accept  = m_tvalid && m_tready;
    assign last_beat = out_half_reg ? (beat_reg == BeatW'(rtpbt_pkg::HalfBeats - 1))
                                    : (beat_reg == BeatW'(rtpbt_pkg::FullBeats - 1));
    assign can_load  = !busy_reg || (m_accept && last_beat);
    assign s1_adv    = s1_valid_reg && (!s1_emit_reg || can_load);
    assign load      = s1_valid_reg && s1_emit_reg && can_load;
    assign s_tready  = !s1_valid_reg || s1_adv;
    assign s_accept  = s_tvalid && s_tready;

    // mode register and frame position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            col_reg  <= '0;
            row_reg  <= '0;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
            col_reg  <= '0;
            row_reg  <= '0;
        end else if (s_accept) begin
            if (col_reg == col_last) begin
                col_reg <= '0;
                row_reg <= (row_reg == row_last) ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // band store write of non-final rows and column read for the input stage
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (!emit) begin
                band_mem[col_reg][rib*8 +: 8] <= s_tdata;
            end
            s1_rd_reg <= band_mem[col_reg];
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_emit_reg <= emit;
            s1_half_reg <= mode_reg;
            s1_px_reg   <= s_tdata;
        end
    end

    // assemble the band rows and transpose into page bytes
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if (i < rtpbt_pkg::StoreLanes) begin
                chunk[i] = s1_rd_reg[i*8 +: 8];
            end else begin
                chunk[i] = s1_px_reg;
            end
        end
        if (s1_half_reg) begin
            chunk[3] = s1_px_reg;
        end
        for (int j = 0; j < 8; j++) begin
            for (int i = 0; i < 8; i++) begin
                if (s1_half_reg) begin
                    page_next[j][i] = chunk[i/2][7-j];
                end else begin
                    page_next[j][i] = chunk[i][7-j];
                end
            end
        end
    end

    // chunk register and beat counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            beat_reg <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            beat_reg <= '0;
        end else if (m_accept) begin
            if (last_beat) begin
                busy_reg <= 1'b0;
            end
            beat_reg <= beat_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_half_reg <= s1_half_reg;
            for (int j = 0; j < 8; j++) begin
                page_reg[j] <= page_next[j];
            end
        end
    end

    // output word select: each page byte twice in half mode
    assign m_tdata = out_half_reg ? page_reg[beat_reg[3:1]] : page_reg[beat_reg[2:0]];
    assign m_tlast = last_beat;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for raster_to_page_bit_transposer: streams raster pixel words through both frame
// modes, predicts the transposed page words and checks every word on the result channel.
// Depends on rtpbt_pkg and the block's RTL only.
module tb;

    localparam int CycleLimit = 400000;
    localparam int LongHold   = 600;
    localparam int DrainWait  = 12;
    localparam int StoreDepth = rtpbt_pkg::StoreLanes * rtpbt_pkg::FullBpr;

    // half mode, three stored rows and the first byte of the band's last row:
    // one chunk built from 0x80, 0x01, 0xA5, 0x5A
    localparam rtpbt_pkg::byte_t DirPixels [25] = '{
        8'h80, 8'h00, 8'hFF, 8'h01, 8'hC0, 8'h7F, 8'hAA, 8'h55,
        8'h01, 8'hFF, 8'h00, 8'h80, 8'h03, 8'hFE, 8'h55, 8'hAA,
        8'hA5, 8'h0F, 8'hF0, 8'h3C, 8'hC3, 8'h00, 8'hFF, 8'h96,
        8'h5A
    };

    typedef struct packed {
        rtpbt_pkg::byte_t page_byte;
        logic             last_of_chunk;
    } page_word_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_ALTERNATE, RX_SPARSE} rx_style_e;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = '0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    // predictor state
    rtpbt_pkg::byte_t band_mem [StoreDepth];
    int    row_pos   = 0;
    int    col_pos   = 0;
    logic  half_mode = 1'b0;

    rtpbt_pkg::byte_t pixel_q [$];
    page_word_t       page_exp_q [$];

    int pushed_cnt = 0;
    int taken_cnt  = 0;
    int fail_cnt   = 0;
    int cycle_cnt  = 0;

    int burst_left = 1;
    int gap_left   = 0;

    logic        long_hold_req  = 1'b0;
    logic        long_hold_done = 1'b0;
    int          hold_left      = 0;
    logic [15:0] rx_pat         = '1;
    logic [3:0]  rx_idx         = '0;

    raster_to_page_bit_transposer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // store a pixel byte or, on a band's last row, transpose its column chunk
    task transpose_pixel(input rtpbt_pkg::byte_t px);
        int               bpr;
        int               rows;
        int               band;
        int               rib;
        rtpbt_pkg::byte_t chunk [8];
        rtpbt_pkg::byte_t pb;
        page_word_t       w;
        bpr  = half_mode ? rtpbt_pkg::HalfBpr : rtpbt_pkg::FullBpr;
        rows = half_mode ? rtpbt_pkg::HalfRows : rtpbt_pkg::FullRows;
        band = half_mode ? 4 : 8;
        rib  = row_pos % band;
        if (col_pos >= bpr)
            col_pos = 0;
        if (rib == band - 1) begin
            for (int i = 0; i < band - 1; i++)
                chunk[i] = band_mem[i * bpr + col_pos];
            chunk[band - 1] = px;
            // leftmost pixel column first
            for (int j = 0; j < 8; j++) begin
                pb = '0;
                for (int i = 0; i < band; i++) begin
                    if (chunk[i][7 - j]) begin
                        if (half_mode)
                            pb[2 * i +: 2] = 2'b11;
                        else
                            pb[i] = 1'b1;
                    end
                end
                w.page_byte     = pb;
                w.last_of_chunk = (j == 7) && !half_mode;
                page_exp_q.push_back(w);
                if (half_mode) begin
                    w.last_of_chunk = (j == 7);
                    page_exp_q.push_back(w);
                end
            end
        end else begin
            band_mem[rib * bpr + col_pos] = px;
        end
        col_pos++;
        if (col_pos >= bpr) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= rows)
                row_pos = 0;
        end
    endtask

    // mode write; restarts the frame on both sides
    task write_mode(input logic mode);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge aclk); while (!cfg_ready);
        half_mode = mode;
        row_pos   = 0;
        col_pos   = 0;
        cfg_valid <= 1'b0;
    endtask

    // random pixel words with extra weight on the extremes
    task queue_pixels(input int n);
        rtpbt_pkg::byte_t px;
        @(negedge aclk);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 7))
                0: px = 8'h00;
                1: px = 8'hFF;
                2: px = 8'h80;
                3: px = 8'h01;
                default: px = rtpbt_pkg::byte_t'($urandom);
            endcase
            pixel_q.push_back(px);
            pushed_cnt++;
        end
    endtask

    // all words taken, all page words seen, pipeline drained
    task wait_idle;
        @(negedge aclk);
        while (taken_cnt != pushed_cnt || page_exp_q.size() != 0)
            @(negedge aclk);
        repeat (DrainWait) @(negedge aclk);
    endtask

    // sequence of phases
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // full mode from reset: first band and two words of the second
        queue_pixels(130);
        wait_idle();

        // directed: mode write mid band, then one half-mode chunk with extreme patterns
        write_mode(1'b1);
        @(negedge aclk);
        foreach (DirPixels[k]) begin
            pixel_q.push_back(DirPixels[k]);
            pushed_cnt++;
        end
        wait_idle();

        // rest of the half frame and past its wrap under a long stall
        long_hold_req <= 1'b1;
        queue_pixels(235);
        wait_idle();

        if (fail_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // sender: bursts of words with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                transpose_pixel(s_tdata);
                taken_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_q.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: ready pattern reloaded whenever its 16 entries are used up, plus one long hold-off
    always @(posedge aclk) begin
        if (long_hold_req && !long_hold_done) begin
            hold_left      = LongHold;
            long_hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_idx == 4'd0) begin
                case (rx_style_e'($urandom_range(0, 3)))
                    RX_OPEN:      rx_pat = '1;
                    RX_RANDOM:    rx_pat = 16'($urandom);
                    RX_ALTERNATE: rx_pat = 16'h5555;
                    RX_SPARSE:    rx_pat = 16'($urandom & $urandom & $urandom);
                    default:      rx_pat = '1;
                endcase
            end
            m_tready <= rx_pat[rx_idx];
            rx_idx = rx_idx + 4'd1;
        end
    end

    // compare each page word with the oldest expectation
    always @(posedge aclk) begin
        page_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (page_exp_q.size() == 0) begin
                $error("page word with none expected: page_byte %02h", m_tdata);
                fail_cnt++;
            end else begin
                want = page_exp_q.pop_front();
                if (m_tdata != want.page_byte) begin
                    $error("page_byte expected %02h actual %02h", want.page_byte, m_tdata);
                    fail_cnt++;
                end
                if (m_tlast != want.last_of_chunk) begin
                    $error("last_of_chunk expected %0b actual %0b",
                           want.last_of_chunk, m_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CycleLimit) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ===== files.f =====
rtl/rtpbt_pkg.sv
rtl/raster_to_page_bit_transposer.sv
verif/tb.sv
